>>> rtl/core/lsegs_pkg.sv
// Shared types, constants and helpers for the label segment stabilizer.
package lsegs_pkg;

  // Default payload widths
  localparam int LABEL_BITS_DEF = 6;
  localparam int CONF_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Configuration register widths
  localparam int CFG_CONF_W = 16;
  localparam int CFG_TIME_W = 32;
  localparam int MASK_W     = 64;
  localparam int MASK_IDX_W = $clog2(MASK_W);

  // Widest label id the mask lookup takes
  localparam int LBL_EXT_W = 8;

  // APB geometry: 64-bit registers at 8-byte strides
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 6;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_CONF      = 3'd0,
    REG_HYST_DELTA    = 3'd1,
    REG_STABLE_TIME   = 3'd2,
    REG_SILENCE_TIME  = 3'd3,
    REG_MIN_SEG_TIME  = 3'd4,
    REG_VOWEL_MASK    = 3'd5,
    REG_UNVOICED_MASK = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_CONF_W-1:0] min_conf;
    logic [CFG_CONF_W-1:0] hyst_delta;
    logic [CFG_TIME_W-1:0] stable_time;
    logic [CFG_TIME_W-1:0] silence_time;
    logic [CFG_TIME_W-1:0] min_seg_time;
    logic [MASK_W-1:0]     vowel_mask;
    logic [MASK_W-1:0]     unvoiced_mask;
  } cfg_t;

  // Look up a label bit; ids past the mask read as zero
  function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                    input logic [LBL_EXT_W-1:0] label);
    logic hit;
    if (label[LBL_EXT_W-1:MASK_IDX_W] != '0) begin
      hit = 1'b0;
    end else begin
      hit = mask[label[MASK_IDX_W-1:0]];
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/lsegs_obs_if.sv
// Observation channel: label id, confidence and timestamp.
interface lsegs_obs_if #(
  parameter int LABEL_BITS = lsegs_pkg::LABEL_BITS_DEF,
  parameter int CONF_BITS  = lsegs_pkg::CONF_BITS_DEF,
  parameter int TIME_BITS  = lsegs_pkg::TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] label_id;
  logic [CONF_BITS-1:0]  confidence;
  logic [TIME_BITS-1:0]  timestamp;

  modport source (output valid, label_id, confidence, timestamp, input ready);
  modport sink   (input valid, label_id, confidence, timestamp, output ready);
endinterface

>>> rtl/core/lsegs_seg_if.sv
// Segment channel: one committed segment per beat.
interface lsegs_seg_if #(
  parameter int LABEL_BITS = lsegs_pkg::LABEL_BITS_DEF,
  parameter int CONF_BITS  = lsegs_pkg::CONF_BITS_DEF,
  parameter int TIME_BITS  = lsegs_pkg::TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LABEL_BITS-1:0] seg_label;
  logic [CONF_BITS-1:0]  seg_confidence;
  logic [TIME_BITS-1:0]  seg_onset;
  logic [TIME_BITS-1:0]  seg_end;
  logic                  is_vowel;
  logic                  is_voiced;

  modport source (output valid, seg_label, seg_confidence, seg_onset, seg_end,
                  is_vowel, is_voiced, input ready);
  modport sink   (input valid, seg_label, seg_confidence, seg_onset, seg_end,
                  is_vowel, is_voiced, output ready);
endinterface

>>> rtl/core/label_segment_stabilizer_unit.sv
// Top level: observation input register, segment core and APB registers.
//
//  channel  | dir | handshake       | beat
//  ---------+-----+-----------------+------------------------------------------
//  obs_i    | in  | valid/ready     | label_id, confidence, timestamp
//  seg_o    | out | valid/ready     | seg_label, seg_confidence, seg_onset,
//           |     |                 | seg_end, is_vowel, is_voiced
//  apb      | in  | psel/penable    | 7 registers at 8-byte strides, 64-bit data
//
// One observation per cycle while seg_o is not stalled: an input register, then
// one pass of compares and subtracts on the segment state into the segment
// output register. Reset clears the segment state, the registers and both
// valid flags. A stalled segment beat holds the core; the input register then
// takes an observation only if it is empty, and obs_i.ready stays low while it
// is full until the beat is taken.
module label_segment_stabilizer_unit #(
  parameter int LABEL_BITS = lsegs_pkg::LABEL_BITS_DEF,
  parameter int CONF_BITS  = lsegs_pkg::CONF_BITS_DEF,
  parameter int TIME_BITS  = lsegs_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lsegs_obs_if.sink                        obs_i,
  lsegs_seg_if.source                      seg_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsegs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lsegs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lsegs_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lsegs_pkg::*;

  cfg_t                  cfg;
  logic                  in_vld_q, take;
  logic [LABEL_BITS-1:0] in_lbl_q;
  logic [CONF_BITS-1:0]  in_conf_q;
  logic [TIME_BITS-1:0]  in_time_q;

  lsegs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept when the input register is empty or being consumed
  assign obs_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (obs_i.ready) begin
      in_vld_q <= obs_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_i.ready && obs_i.valid) begin
      in_lbl_q  <= obs_i.label_id;
      in_conf_q <= obs_i.confidence;
      in_time_q <= obs_i.timestamp;
    end
  end

  lsegs_core #(
    .LABEL_BITS (LABEL_BITS),
    .CONF_BITS  (CONF_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_vld_i   (in_vld_q),
    .item_label_i (in_lbl_q),
    .item_conf_i  (in_conf_q),
    .item_time_i  (in_time_q),
    .item_take_o  (take),
    .seg_o        (seg_o)
  );

endmodule

>>> rtl/core/lsegs_cfg.sv
// APB register file holding the stabilizer thresholds and label masks.
module lsegs_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lsegs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lsegs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lsegs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  output lsegs_pkg::cfg_t                   cfg_o
);
  import lsegs_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:REG_IDX_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_CONF:      cfg_q.min_conf      <= pwdata[CFG_CONF_W-1:0];
        REG_HYST_DELTA:    cfg_q.hyst_delta    <= pwdata[CFG_CONF_W-1:0];
        REG_STABLE_TIME:   cfg_q.stable_time   <= pwdata[CFG_TIME_W-1:0];
        REG_SILENCE_TIME:  cfg_q.silence_time  <= pwdata[CFG_TIME_W-1:0];
        REG_MIN_SEG_TIME:  cfg_q.min_seg_time  <= pwdata[CFG_TIME_W-1:0];
        REG_VOWEL_MASK:    cfg_q.vowel_mask    <= pwdata[MASK_W-1:0];
        REG_UNVOICED_MASK: cfg_q.unvoiced_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_MIN_CONF:      prdata = APB_DATA_W'(cfg_q.min_conf);
      REG_HYST_DELTA:    prdata = APB_DATA_W'(cfg_q.hyst_delta);
      REG_STABLE_TIME:   prdata = APB_DATA_W'(cfg_q.stable_time);
      REG_SILENCE_TIME:  prdata = APB_DATA_W'(cfg_q.silence_time);
      REG_MIN_SEG_TIME:  prdata = APB_DATA_W'(cfg_q.min_seg_time);
      REG_VOWEL_MASK:    prdata = APB_DATA_W'(cfg_q.vowel_mask);
      REG_UNVOICED_MASK: prdata = APB_DATA_W'(cfg_q.unvoiced_mask);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/lsegs_core.sv
// Segment state update and the registered segment output.
module lsegs_core #(
  parameter int LABEL_BITS = lsegs_pkg::LABEL_BITS_DEF,
  parameter int CONF_BITS  = lsegs_pkg::CONF_BITS_DEF,
  parameter int TIME_BITS  = lsegs_pkg::TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsegs_pkg::cfg_t       cfg_i,
  input  logic                  item_vld_i,
  input  logic [LABEL_BITS-1:0] item_label_i,
  input  logic [CONF_BITS-1:0]  item_conf_i,
  input  logic [TIME_BITS-1:0]  item_time_i,
  output logic                  item_take_o,
  lsegs_seg_if.source           seg_o
);
  import lsegs_pkg::*;

  localparam int TCMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam int CCMP_W = (CONF_BITS > CFG_CONF_W) ? CONF_BITS + 1 : CFG_CONF_W + 1;

  // Segment state
  logic [LABEL_BITS-1:0] act_lbl_q, act_lbl_d, cand_lbl_q, cand_lbl_d;
  logic [TIME_BITS-1:0]  act_start_q, act_start_d, act_last_q, act_last_d;
  logic [TIME_BITS-1:0]  cand_start_q, cand_start_d, sil_start_q, sil_start_d;
  logic [TIME_BITS-1:0]  prev_time_q;
  logic [CONF_BITS-1:0]  act_peak_q, act_peak_d, cand_peak_q, cand_peak_d;
  logic                  in_sil_q, in_sil_d, seen_any_q;

  // State after a possible backward-time clear
  logic [LABEL_BITS-1:0] act_lbl_e, cand_lbl_e;
  logic [TIME_BITS-1:0]  act_start_e, act_last_e, cand_start_e, sil_start_e;
  logic [CONF_BITS-1:0]  act_peak_e, cand_peak_e;
  logic                  in_sil_e, back_time;

  // Per-item decisions
  logic                  voiced, dur_ok, emit;
  logic [CCMP_W-1:0]     floor_sw;
  logic [TIME_BITS-1:0]  sil_ref, sil_len, cand_len, seg_len;
  logic [CONF_BITS-1:0]  cand_peak_new;

  // Output register
  logic                  out_vld_q;
  logic [LABEL_BITS-1:0] out_lbl_q;
  logic [CONF_BITS-1:0]  out_conf_q;
  logic [TIME_BITS-1:0]  out_onset_q, out_end_q;
  logic                  out_vowel_q, out_voiced_q;
  logic                  vowel_bit, unvoiced_bit;

  // Take an item whenever the output slot is free or draining
  assign item_take_o = item_vld_i && (!out_vld_q || seg_o.ready);

  // Clear state on a timestamp that goes backwards
  always_comb begin
    back_time = seen_any_q && (item_time_i < prev_time_q);
    if (back_time) begin
      act_lbl_e    = '0;
      act_start_e  = '0;
      act_last_e   = '0;
      act_peak_e   = '0;
      cand_lbl_e   = '0;
      cand_start_e = '0;
      cand_peak_e  = '0;
      in_sil_e     = 1'b0;
      sil_start_e  = '0;
    end else begin
      act_lbl_e    = act_lbl_q;
      act_start_e  = act_start_q;
      act_last_e   = act_last_q;
      act_peak_e   = act_peak_q;
      cand_lbl_e   = cand_lbl_q;
      cand_start_e = cand_start_q;
      cand_peak_e  = cand_peak_q;
      in_sil_e     = in_sil_q;
      sil_start_e  = sil_start_q;
    end
  end

  // Thresholds, and elapsed times modulo the time width
  assign voiced   = (item_label_i != '0) &&
                    (CCMP_W'(item_conf_i) >= CCMP_W'(cfg_i.min_conf));
  assign floor_sw = CCMP_W'(cfg_i.min_conf) + CCMP_W'(cfg_i.hyst_delta);
  assign sil_ref  = in_sil_e ? sil_start_e : item_time_i;
  assign sil_len  = item_time_i - sil_ref;
  assign cand_len = item_time_i - cand_start_e;
  assign seg_len  = act_last_e - act_start_e;
  assign dur_ok   = TCMP_W'(seg_len) >= TCMP_W'(cfg_i.min_seg_time);
  assign cand_peak_new = (item_conf_i > cand_peak_e) ? item_conf_i : cand_peak_e;

  // Next state and whether the active segment is emitted
  always_comb begin
    act_lbl_d    = act_lbl_e;
    act_start_d  = act_start_e;
    act_last_d   = act_last_e;
    act_peak_d   = act_peak_e;
    cand_lbl_d   = cand_lbl_e;
    cand_start_d = cand_start_e;
    cand_peak_d  = cand_peak_e;
    in_sil_d     = in_sil_e;
    sil_start_d  = sil_start_e;
    emit         = 1'b0;
    if (!voiced) begin
      // Open a silence run, finish the segment once it is long enough
      in_sil_d    = 1'b1;
      sil_start_d = sil_ref;
      if (act_lbl_e != '0 && TCMP_W'(sil_len) >= TCMP_W'(cfg_i.silence_time)) begin
        emit       = dur_ok;
        act_lbl_d  = '0;
        act_peak_d = '0;
        cand_lbl_d = '0;
        in_sil_d   = 1'b0;
      end
    end else begin
      in_sil_d = 1'b0;
      priority if (act_lbl_e == '0) begin
        act_lbl_d   = item_label_i;
        act_start_d = item_time_i;
        act_last_d  = item_time_i;
        act_peak_d  = item_conf_i;
        cand_lbl_d  = '0;
      end else if (item_label_i == act_lbl_e) begin
        act_last_d = item_time_i;
        if (item_conf_i > act_peak_e) begin
          act_peak_d = item_conf_i;
        end
        cand_lbl_d = '0;
      end else if (CCMP_W'(item_conf_i) < floor_sw) begin
        // weak competitor: ignore
      end else if (cand_lbl_e != item_label_i) begin
        cand_lbl_d   = item_label_i;
        cand_start_d = item_time_i;
        cand_peak_d  = item_conf_i;
      end else begin
        cand_peak_d = cand_peak_new;
        // Switch once the candidate has held long enough
        if (TCMP_W'(cand_len) >= TCMP_W'(cfg_i.stable_time) &&
            CCMP_W'(cand_peak_new) >= floor_sw) begin
          emit        = dur_ok;
          act_lbl_d   = item_label_i;
          act_start_d = cand_start_e;
          act_last_d  = item_time_i;
          act_peak_d  = cand_peak_new;
          cand_lbl_d  = '0;
        end
      end
    end
  end

  // Label class flags of the finished segment
  assign vowel_bit    = mask_bit(cfg_i.vowel_mask, LBL_EXT_W'(act_lbl_e));
  assign unvoiced_bit = mask_bit(cfg_i.unvoiced_mask, LBL_EXT_W'(act_lbl_e));

  // Advance segment control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_lbl_q   <= '0;
      cand_lbl_q  <= '0;
      in_sil_q    <= 1'b0;
      seen_any_q  <= 1'b0;
      prev_time_q <= '0;
      act_start_q <= '0;
      act_last_q  <= '0;
      act_peak_q  <= '0;
      cand_start_q <= '0;
      cand_peak_q <= '0;
      sil_start_q <= '0;
    end else if (item_take_o) begin
      act_lbl_q    <= act_lbl_d;
      cand_lbl_q   <= cand_lbl_d;
      in_sil_q     <= in_sil_d;
      seen_any_q   <= 1'b1;
      prev_time_q  <= item_time_i;
      act_start_q  <= act_start_d;
      act_last_q   <= act_last_d;
      act_peak_q   <= act_peak_d;
      cand_start_q <= cand_start_d;
      cand_peak_q  <= cand_peak_d;
      sil_start_q  <= sil_start_d;
    end
  end

  // Hold a segment beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (item_take_o) begin
      out_vld_q <= emit;
    end else if (seg_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Load the segment payload
  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      out_lbl_q    <= act_lbl_e;
      out_conf_q   <= act_peak_e;
      out_onset_q  <= act_start_e;
      out_end_q    <= act_last_e;
      out_vowel_q  <= vowel_bit;
      out_voiced_q <= vowel_bit || !unvoiced_bit;
    end
  end

  assign seg_o.valid          = out_vld_q;
  assign seg_o.seg_label      = out_lbl_q;
  assign seg_o.seg_confidence = out_conf_q;
  assign seg_o.seg_onset      = out_onset_q;
  assign seg_o.seg_end        = out_end_q;
  assign seg_o.is_vowel       = out_vowel_q;
  assign seg_o.is_voiced      = out_voiced_q;

  // A committed segment never carries the empty label
  a_seg_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_lbl_q != '0)
    else $error("segment beat with empty label");

  // No candidate without an active segment, and never the active label
  a_cand_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_lbl_q == '0 |-> cand_lbl_q == '0) &&
    (cand_lbl_q == '0 || cand_lbl_q != act_lbl_q))
    else $error("candidate label inconsistent with active label");

  // A taken item records its time as the reference for backward detection
  a_prev_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |=> seen_any_q && prev_time_q == $past(item_time_i))
    else $error("previous time not recorded");

  // A vowel is always voiced
  a_vowel_voiced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_vowel_q |-> out_voiced_q)
    else $error("vowel segment flagged unvoiced");

endmodule
